FILE: hw/rtl/mpmp_pkg.sv
// min-plus matrix product: shared types and constants
// used by the acc, ctrl and core modules and the bench; depends on nothing
`default_nettype none

package mpmp_pkg;

    // fixed field widths
    localparam int IDX_W  = 6;
    localparam int SIZE_W = 7;
    localparam int APB_AW = 3;

    // size register reset value
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // register indexes
    localparam logic [APB_AW-3:0] REG_SIZE = 1'b0;

    // request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    // control from sequencer to add-compare unit
    typedef struct packed {
        logic clear;
        logic en;
    } t_acc_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/mpmp_ram.sv
// generic ram: one write port, two registered read ports
// no package dependency
`default_nettype none

module mpmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mpmp_acc.sv
// shared saturating add and running-minimum unit
// depends on mpmp_pkg for the control struct
`default_nettype none

module mpmp_acc #(
    parameter int W = 16
) (
    input  wire logic               i_clk,
    input  wire mpmp_pkg::t_acc_ctl i_ctl,
    input  wire logic [W-1:0]       i_a,
    input  wire logic [W-1:0]       i_b,
    output logic      [W-1:0]       o_best
);

    localparam logic [W-1:0] INF = {W{1'b1}};

    logic [W:0]   w_sum;
    logic [W-1:0] w_z;
    logic [W-1:0] r_best;
    logic [W-1:0] n_best;

    // saturating sum, infinity absorbs
    assign w_sum = {1'b0, i_a} + {1'b0, i_b};
    assign w_z   = (i_a == INF || i_b == INF || w_sum >= {1'b0, INF}) ? INF : w_sum[W-1:0];

    // running minimum
    always_comb begin
        n_best = r_best;
        if (i_ctl.clear) begin
            n_best = INF;
        end else if (i_ctl.en && w_z < r_best) begin
            n_best = w_z;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_best = r_best;

endmodule

`default_nettype wire

FILE: hw/rtl/mpmp_ctrl.sv
// sequencer: accepts requests, writes loads, walks k for queries
// depends on mpmp_pkg for state type, widths and codes
`default_nettype none

module mpmp_ctrl #(
    parameter int MAX_SIZE = 64,
    parameter int ADDR_W   = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic                         i_kind,
    input  wire logic [mpmp_pkg::IDX_W-1:0]   i_row,
    input  wire logic [mpmp_pkg::IDX_W-1:0]   i_col,
    input  wire logic [mpmp_pkg::SIZE_W-1:0]  i_size,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [mpmp_pkg::IDX_W-1:0]        o_row,
    output logic [mpmp_pkg::IDX_W-1:0]        o_col,
    output logic                              o_we,
    output logic [ADDR_W-1:0]                 o_waddr,
    output logic [ADDR_W-1:0]                 o_raddr_a,
    output logic [ADDR_W-1:0]                 o_raddr_b,
    output mpmp_pkg::t_acc_ctl                o_acc
);

    localparam int SW = mpmp_pkg::SIZE_W;

    mpmp_pkg::t_state r_state, n_state;
    logic [SW-1:0] r_k, n_k;
    logic [SW-1:0] r_n, n_n;
    logic [mpmp_pkg::IDX_W-1:0] r_row, n_row, r_col, n_col;
    logic r_issue;
    logic w_accept;
    logic w_in_range;
    logic [SW-1:0] w_n_sat;

    assign w_accept   = i_start && (r_state == mpmp_pkg::S_IDLE);
    assign w_in_range = (32'(i_row) < 32'(MAX_SIZE)) && (32'(i_col) < 32'(MAX_SIZE));
    assign w_n_sat    = (32'(i_size) > 32'(MAX_SIZE)) ? SW'(MAX_SIZE) : i_size;

    // next state and outputs
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_n     = r_n;
        n_row   = r_row;
        n_col   = r_col;
        o_we    = 1'b0;
        o_acc.clear = 1'b0;
        o_acc.en    = r_issue;
        case (r_state)
            mpmp_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_kind == mpmp_pkg::KIND_LOAD) begin
                        o_we = w_in_range;
                    end else begin
                        n_row = i_row;
                        n_col = i_col;
                        n_n   = w_n_sat;
                        n_k   = '0;
                        o_acc.clear = 1'b1;
                        if (w_in_range && w_n_sat != '0) begin
                            n_state = mpmp_pkg::S_RUN;
                        end else begin
                            n_state = mpmp_pkg::S_DONE;
                        end
                    end
                end
            end
            mpmp_pkg::S_RUN: begin
                if ((r_k + SW'(1)) == r_n) begin
                    n_state = mpmp_pkg::S_DRAIN;
                end else begin
                    n_k = r_k + SW'(1);
                end
            end
            mpmp_pkg::S_DRAIN: begin
                n_state = mpmp_pkg::S_DONE;
            end
            mpmp_pkg::S_DONE: begin
                n_state = mpmp_pkg::S_IDLE;
            end
            default: begin
                n_state = mpmp_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpmp_pkg::S_IDLE;
            r_k     <= '0;
            r_issue <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_issue <= (r_state == mpmp_pkg::S_RUN);
        end
    end

    // query payload registers
    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_row <= n_row;
        r_col <= n_col;
    end

    // entry addresses: row-major, stride MAX_SIZE
    assign o_waddr   = ADDR_W'(i_row) * ADDR_W'(MAX_SIZE) + ADDR_W'(i_col);
    assign o_raddr_a = ADDR_W'(r_row) * ADDR_W'(MAX_SIZE) + ADDR_W'(r_k);
    assign o_raddr_b = ADDR_W'(r_k) * ADDR_W'(MAX_SIZE) + ADDR_W'(r_col);

    assign o_busy = (r_state != mpmp_pkg::S_IDLE);
    assign o_done = (r_state == mpmp_pkg::S_DONE);
    assign o_row  = r_row;
    assign o_col  = r_col;

endmodule

`default_nettype wire

FILE: hw/rtl/min_plus_matrix_product_core.sv
// min-plus matrix product core: stored matrix, apb size register, query sequencer
// depends on mpmp_pkg, mpmp_ram, mpmp_acc and mpmp_ctrl
//
// usage:
// - request channel: i_start with i_kind/i_row/i_col/i_weight is taken at a clock
//   edge where i_start is high and o_busy is low
// - a load request writes one entry in its accept cycle and leaves o_busy low,
//   so loads can come every cycle; loads outside the matrix are dropped
// - a query request raises o_busy and walks k = 0 .. n-1, n = size_in_use
//   capped at MAX_SIZE, one dual-port ram read and one saturating add and
//   compare per cycle through a single shared unit
// - o_valid is high in the done state that follows the k walk and a drain state (the next
//   cycle for an index outside the matrix or a size of zero); a new request is taken
//   from the cycle after the strobe
// - o_valid lasts one cycle; the receiver cannot stall, results are not held
// - apb: size_in_use at byte address 0, pready high; write it only while idle,
//   a running query keeps the size it latched at its accept edge
// - reset (synchronous, active low) returns the sequencer to idle and the size
//   to 64; matrix contents are not cleared and must be loaded before use
`default_nettype none

module min_plus_matrix_product_core #(
    parameter int MAX_SIZE    = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic                                i_kind,
    input  wire logic [mpmp_pkg::IDX_W-1:0]          i_row,
    input  wire logic [mpmp_pkg::IDX_W-1:0]          i_col,
    input  wire logic [WEIGHT_BITS-1:0]              i_weight,
    output logic                                     o_valid,
    output logic [WEIGHT_BITS-1:0]                   o_distance,
    output logic [mpmp_pkg::IDX_W-1:0]               o_result_row,
    output logic [mpmp_pkg::IDX_W-1:0]               o_result_col,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mpmp_pkg::APB_AW-1:0]         paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [mpmp_pkg::SIZE_W-1:0] r_size;
    logic                        w_cfg_wr;
    logic                        w_we;
    logic [ADDR_W-1:0]           w_waddr;
    logic [ADDR_W-1:0]           w_raddr_a;
    logic [ADDR_W-1:0]           w_raddr_b;
    logic [WEIGHT_BITS-1:0]      w_rdata_a;
    logic [WEIGHT_BITS-1:0]      w_rdata_b;
    mpmp_pkg::t_acc_ctl          w_acc;

    // apb size register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= mpmp_pkg::SIZE_RESET;
        end else if (w_cfg_wr && paddr[mpmp_pkg::APB_AW-1:2] == mpmp_pkg::REG_SIZE) begin
            r_size <= pwdata[mpmp_pkg::SIZE_W-1:0];
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        if (paddr[mpmp_pkg::APB_AW-1:2] == mpmp_pkg::REG_SIZE) begin
            prdata = 32'(r_size);
        end
    end

    // sequencer
    mpmp_ctrl #(
        .MAX_SIZE (MAX_SIZE),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_kind    (i_kind),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_size    (r_size),
        .o_busy    (o_busy),
        .o_done    (o_valid),
        .o_row     (o_result_row),
        .o_col     (o_result_col),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_raddr_a (w_raddr_a),
        .o_raddr_b (w_raddr_b),
        .o_acc     (w_acc)
    );

    // matrix store
    mpmp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (i_weight),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // shared add-compare unit
    mpmp_acc #(
        .W (WEIGHT_BITS)
    ) u_acc (
        .i_clk  (i_clk),
        .i_ctl  (w_acc),
        .i_a    (w_rdata_a),
        .i_b    (w_rdata_b),
        .o_best (o_distance)
    );

    // result strobe only while busy
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe while idle");

    // a query request makes the block busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_kind == mpmp_pkg::KIND_QUERY) |=> o_busy)
        else $error("query accepted without going busy");

    // a load request never makes the block busy
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_kind == mpmp_pkg::KIND_LOAD) |=> !o_busy)
        else $error("load left block busy");

    // busy ends only right after a result strobe
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && $past(o_busy) && $past(i_rst_n)) |-> $past(o_valid))
        else $error("busy dropped without a result");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// testbench for the min-plus matrix product core: directed and random load and query
// requests checked against a predictor held in the bench; depends on mpmp_pkg and the core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM           = 64;
    localparam int WBITS         = 16;
    localparam int SETTLE_CYCLES = 70;
    localparam int TARGET_ITEMS  = 1850;
    localparam int PHASE_ITEMS   = 120;
    localparam logic [WBITS-1:0]  W_INF     = '1;
    localparam logic [mpmp_pkg::APB_AW-1:0] SIZE_ADDR = {mpmp_pkg::REG_SIZE, 2'b00};

    typedef struct packed {
        logic                       kind;
        logic [mpmp_pkg::IDX_W-1:0] row;
        logic [mpmp_pkg::IDX_W-1:0] col;
        logic [WBITS-1:0]           weight;
    } t_req;

    typedef struct packed {
        logic [WBITS-1:0]           distance;
        logic [mpmp_pkg::IDX_W-1:0] row;
        logic [mpmp_pkg::IDX_W-1:0] col;
    } t_dist;

    // dut ports, all inputs known from time zero
    logic                          i_clk    = 1'b0;
    logic                          i_rst_n  = 1'b0;
    logic                          i_start  = 1'b0;
    logic                          i_kind   = mpmp_pkg::KIND_LOAD;
    logic [mpmp_pkg::IDX_W-1:0]    i_row    = '0;
    logic [mpmp_pkg::IDX_W-1:0]    i_col    = '0;
    logic [WBITS-1:0]              i_weight = '0;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [mpmp_pkg::APB_AW-1:0]   paddr    = '0;
    logic [31:0]                   pwdata   = '0;
    logic                          o_busy;
    logic                          o_valid;
    logic [WBITS-1:0]              o_distance;
    logic [mpmp_pkg::IDX_W-1:0]    o_result_row;
    logic [mpmp_pkg::IDX_W-1:0]    o_result_col;
    logic [31:0]                   prdata;
    logic                          pready;

    // request stream and expected distances
    t_req  pending_reqs [$];
    t_dist dist_expected [$];

    // predictor copy of the block state
    logic [WBITS-1:0]            dist_model [0:DIM*DIM-1];
    logic [mpmp_pkg::SIZE_W-1:0] size_model = mpmp_pkg::SIZE_RESET;

    // entries already scheduled for loading, so queries never read unwritten cells
    bit entry_loaded [0:DIM*DIM-1];

    int   gen_items  = 0;
    int   n_queries  = 0;
    int   n_loads    = 0;
    int   n_inf      = 0;
    int   n_cfg      = 0;
    int   mismatches = 0;
    int   gap_left   = 0;
    int   calm_left  = 0;
    logic req_taken  = 1'b0;
    t_req  drv_req;
    t_dist want;

    int phase_sizes [0:17] = '{1, 5, 64, 0, 3, 127, 9, 2, 16, 65, 7, 4, 12, 100, 6, 1, 33, 8};
    int hub_lines [0:3] = '{0, 1, 62, 63};

    min_plus_matrix_product_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_kind       (i_kind),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_weight     (i_weight),
        .o_valid      (o_valid),
        .o_distance   (o_distance),
        .o_result_row (o_result_row),
        .o_result_col (o_result_col),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // saturating min-plus value over the first size_in_use terms
    function automatic logic [WBITS-1:0] min_plus_at(input logic [mpmp_pkg::IDX_W-1:0] r,
                                                     input logic [mpmp_pkg::IDX_W-1:0] c);
        int               span;
        logic [WBITS:0]   total;
        logic [WBITS-1:0] a;
        logic [WBITS-1:0] b;
        logic [WBITS-1:0] best;
        span = (size_model > DIM) ? DIM : int'(size_model);
        best = W_INF;
        for (int k = 0; k < span; k++) begin
            a = dist_model[r*DIM + k];
            b = dist_model[k*DIM + c];
            if (a == W_INF || b == W_INF)
                total = {1'b0, W_INF};
            else
                total = {1'b0, a} + {1'b0, b};
            if (total > {1'b0, W_INF})
                total = {1'b0, W_INF};
            if (total < {1'b0, best})
                best = total[WBITS-1:0];
        end
        return best;
    endfunction

    // weights lean toward small values, with infinity and near-saturation mixed in
    function automatic logic [WBITS-1:0] draw_weight();
        case ($urandom_range(0, 15))
            0:       return W_INF;
            1:       return '0;
            2, 3:    return WBITS'($urandom_range(30000, 65534));
            4:       return WBITS'($urandom_range(65000, 65534));
            default: return WBITS'($urandom_range(1, 3000));
        endcase
    endfunction

    task automatic push_load(input int r, input int c, input logic [WBITS-1:0] w);
        pending_reqs.push_back({mpmp_pkg::KIND_LOAD, r[mpmp_pkg::IDX_W-1:0],
                                c[mpmp_pkg::IDX_W-1:0], w});
        entry_loaded[r*DIM + c] = 1'b1;
        gen_items++;
    endtask

    task automatic push_query(input int r, input int c);
        logic [WBITS-1:0] junk;
        junk = WBITS'($urandom);
        pending_reqs.push_back({mpmp_pkg::KIND_QUERY, r[mpmp_pkg::IDX_W-1:0],
                                c[mpmp_pkg::IDX_W-1:0], junk});
        gen_items++;
    endtask

    // loads every cell the query reads that is still unwritten, optionally refreshes some
    task automatic queue_query(input int r, input int c, input int span, input bit refresh);
        for (int k = 0; k < span; k++) begin
            if (!entry_loaded[r*DIM + k] || (refresh && $urandom_range(0, 3) == 0))
                push_load(r, k, draw_weight());
            if (!entry_loaded[k*DIM + c] || (refresh && $urandom_range(0, 3) == 0))
                push_load(k, c, draw_weight());
        end
        push_query(r, c);
    endtask

    // apb write of the size register: setup then access
    task automatic write_size(input logic [mpmp_pkg::SIZE_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = SIZE_ADDR;
        pwdata  = $urandom;
        pwdata[mpmp_pkg::SIZE_W-1:0] = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        n_cfg++;
    endtask

    // hold off until every request is taken and every distance has come back
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_start || dist_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // request driver: holds a request until taken, then idles a random gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || req_taken) begin
            if (gap_left > 0) begin
                i_start  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
                drv_req = pending_reqs.pop_front();
                i_kind   <= drv_req.kind;
                i_row    <= drv_req.row;
                i_col    <= drv_req.col;
                i_weight <= drv_req.weight;
                i_start  <= 1'b1;
                if (calm_left > 0) begin
                    calm_left = calm_left - 1;
                    gap_left <= 0;
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        calm_left = $urandom_range(10, 40);
                    gap_left <= $urandom_range(0, 11);
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: checks distances, tracks config writes, predicts accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (dist_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: distance %0d for (%0d,%0d) with no query pending",
                                 $realtime, o_distance, o_result_row, o_result_col);
                end else begin
                    want = dist_expected.pop_front();
                    if (o_distance !== want.distance || o_result_row !== want.row ||
                        o_result_col !== want.col) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected distance %0d at (%0d,%0d), %s",
                                     $realtime, want.distance, want.row, want.col,
                                     $sformatf("got %0d at (%0d,%0d)", o_distance,
                                               o_result_row, o_result_col));
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == SIZE_ADDR)
                size_model = pwdata[mpmp_pkg::SIZE_W-1:0];
            if (i_start && !o_busy) begin
                if (i_kind == mpmp_pkg::KIND_LOAD) begin
                    dist_model[i_row*DIM + i_col] = i_weight;
                    n_loads++;
                end else begin
                    want.distance = min_plus_at(i_row, i_col);
                    want.row      = i_row;
                    want.col      = i_col;
                    dist_expected.push_back(want);
                    n_queries++;
                    if (want.distance == W_INF)
                        n_inf++;
                end
            end
        end
        req_taken <= i_rst_n && i_start && !o_busy;
    end

    // stimulus
    initial begin
        int phase_idx;
        int span;
        int phase_start;
        int r;
        int c;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: size two, extreme weights and indices, saturation to infinity
        write_size(mpmp_pkg::SIZE_W'(2));
        push_load(0, 0, '0);
        push_load(0, 1, W_INF);
        push_load(1, 0, WBITS'(1));
        push_load(1, 1, WBITS'(40000));
        push_load(63, 0, WBITS'(65534));
        push_load(63, 1, WBITS'(1));
        push_load(0, 63, WBITS'(1));
        push_load(1, 63, W_INF);
        push_query(0, 0);
        push_query(1, 1);
        push_query(0, 1);
        push_query(1, 0);
        // sum lands exactly on the infinity code
        push_query(63, 63);
        push_query(0, 63);
        push_query(63, 0);
        wait_drained();

        // empty minimum gives infinity
        write_size('0);
        push_query(5, 9);
        push_query(63, 0);
        wait_drained();

        // random phases, each at a new size and fully drained before the next write
        phase_idx = 0;
        while (gen_items < TARGET_ITEMS) begin
            write_size(mpmp_pkg::SIZE_W'(phase_sizes[phase_idx % 18]));
            span = (phase_sizes[phase_idx % 18] > DIM) ? DIM : phase_sizes[phase_idx % 18];
            phase_start = gen_items;
            while (gen_items - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    // stray load anywhere in the matrix
                    push_load($urandom_range(0, 63), $urandom_range(0, 63), draw_weight());
                end else if (span > 16) begin
                    // large sizes stay on a few rows and columns to bound the loads
                    r = hub_lines[$urandom_range(0, 3)];
                    c = hub_lines[$urandom_range(0, 3)];
                    queue_query(r, c, span, 1'b0);
                end else begin
                    if ($urandom_range(0, 1) == 0 && span > 0) begin
                        r = $urandom_range(0, span - 1);
                        c = $urandom_range(0, span - 1);
                    end else begin
                        r = $urandom_range(0, 63);
                        c = $urandom_range(0, 63);
                    end
                    queue_query(r, c, span, 1'b1);
                end
            end
            wait_drained();
            phase_idx++;
        end

        $display("checked %0d query results (%0d at infinity) after %0d loads",
                 n_queries, n_inf, n_loads);
        $display("over %0d size register writes covering sizes 0 through 127",
                 n_cfg);
        if (mismatches == 0 && dist_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
